// ===== sv/sqcb_pkg.sv =====
// ----------------------------------------------------------------------------
// sqcb_pkg: shared types and constants for the square crop box block
// Field widths, register indexes, fixed-point constants and the command
// word passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package sqcb_pkg;

  // keypoint and box field widths
  localparam int PT_W    = 17;
  localparam int FRAME_W = 13;
  localparam int POS_W   = 13;
  localparam int SIZE_W  = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = FRAME_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // tracker clear values
  localparam logic signed [PT_W-1:0] TRACK_MAX = 17'sd65535;
  localparam logic signed [PT_W-1:0] TRACK_MIN = -17'sd65536;

  // fixed point: default input fraction bits, extra internal fraction bits
  localparam int FRAC_BITS_DEF = 4;
  localparam int EXTRA_BITS    = 15;
  // 1.4 in Q2.14
  localparam int Y_SCALE_Q14   = 22938;

  // output saturation limits
  localparam int POS_MIN  = -4096;
  localparam int POS_MAX  = 4095;
  localparam int SIZE_MAX = 4095;

  // one-hot style step commands
  typedef struct packed {
    logic track;     // fold accepted point into trackers
    logic span;      // widened box terms, clear trackers
    logic clip_x;    // top/height, clip x corner and width
    logic clip_y;    // clip y corner and height
    logic side;      // larger side of the square
    logic corner;    // square corner about clipped centre
    logic load_out;  // quotient + saturate into output register
  } cmd_t;

endpackage

// ===== sv/sqcb_if.sv =====
// ----------------------------------------------------------------------------
// sqcb_if: keypoint and box channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sqcb_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sqcb_pkg::PT_W-1:0]      point_x;
  logic signed [sqcb_pkg::PT_W-1:0]      point_y;
  logic                                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface sqcb_box_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sqcb_pkg::POS_W-1:0]     box_left;
  logic signed [sqcb_pkg::POS_W-1:0]     box_top;
  logic        [sqcb_pkg::SIZE_W-1:0]    box_width;
  logic        [sqcb_pkg::SIZE_W-1:0]    box_height;

  modport source (output valid, output box_left, output box_top, output box_width,
                  output box_height, input ready);
  modport sink   (input valid, input box_left, input box_top, input box_width,
                  input box_height, output ready);
endinterface

// ===== sv/sqcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqcb_ctrl: sequencer for the square crop box
// Takes points in idle, owns the output valid flag and, after a last point,
// walks the box computation one step per cycle, stalling only at output load.
// ----------------------------------------------------------------------------
module sqcb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_point_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output sqcb_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPAN   = 3'd1;
  localparam logic [2:0] ST_CLIP_X = 3'd2;
  localparam logic [2:0] ST_CLIP_Y = 3'd3;
  localparam logic [2:0] ST_SIDE   = 3'd4;
  localparam logic [2:0] ST_CORNER = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cmd_o.track = accept;
        if (accept && last_point_i) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = ST_CLIP_X;
      end
      ST_CLIP_X: begin
        cmd_o.clip_x = 1'b1;
        state_d      = ST_CLIP_Y;
      end
      ST_CLIP_Y: begin
        cmd_o.clip_y = 1'b1;
        state_d      = ST_SIDE;
      end
      ST_SIDE: begin
        cmd_o.side = 1'b1;
        state_d    = ST_CORNER;
      end
      ST_CORNER: begin
        cmd_o.corner = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous box word is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/sqcb_datapath.sv =====
// ----------------------------------------------------------------------------
// sqcb_datapath: trackers, box arithmetic and output register
// Min/max trackers, frame size registers and the staged fixed-point box
// computation, each stage loaded on its command bit.
// ----------------------------------------------------------------------------
module sqcb_datapath #(
  parameter int FRAC_BITS = sqcb_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sqcb_pkg::cmd_t                         cmd_i,
  input  logic                                   cfg_we_i,
  input  logic [sqcb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [sqcb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [sqcb_pkg::PT_W-1:0]       point_x_i,
  input  logic signed [sqcb_pkg::PT_W-1:0]       point_y_i,
  output logic signed [sqcb_pkg::POS_W-1:0]      box_left_o,
  output logic signed [sqcb_pkg::POS_W-1:0]      box_top_o,
  output logic        [sqcb_pkg::SIZE_W-1:0]     box_width_o,
  output logic        [sqcb_pkg::SIZE_W-1:0]     box_height_o
);

  // internal units carry FRAC_BITS + EXTRA_BITS fraction bits
  localparam int W       = FRAC_BITS + 40;
  localparam int SH_ONE  = FRAC_BITS + sqcb_pkg::EXTRA_BITS;
  localparam int SH_HALF = SH_ONE + 1;
  localparam int PROD_W  = 33;

  typedef logic signed [W-1:0] wide_t;

  function automatic wide_t clip_to(input wide_t v, input wide_t hi);
    wide_t m;
    m = (v < hi) ? v : hi;
    return (m < wide_t'(0)) ? wide_t'(0) : m;
  endfunction

  // shift right, rounding toward zero
  function automatic wide_t trunc_shift(input wide_t v, input int sh);
    wide_t bias;
    wide_t sum;
    bias = (wide_t'(1) <<< sh) - wide_t'(1);
    sum  = v + (v[W-1] ? bias : wide_t'(0));
    return sum >>> sh;
  endfunction

  function automatic wide_t clamp(input wide_t v, input int lo, input int hi);
    wide_t r;
    r = v;
    if (v < wide_t'(lo)) r = wide_t'(lo);
    if (v > wide_t'(hi)) r = wide_t'(hi);
    return r;
  endfunction

  // configuration and trackers
  logic        [sqcb_pkg::FRAME_W-1:0] frame_w_q, frame_w_d;
  logic        [sqcb_pkg::FRAME_W-1:0] frame_h_q, frame_h_d;
  logic signed [sqcb_pkg::PT_W-1:0]    lx_q, lx_d, ly_q, ly_d, gx_q, gx_d, gy_q, gy_d;

  // staged box values
  wide_t              left_q, left_d, wid_q, wid_d, ysum_q, ysum_d;
  wide_t              limx_q, limx_d, limy_q, limy_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  wide_t              top_q, top_d, hgt_q, hgt_d;
  wide_t              r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  wide_t              side_q, side_d, left2_q, left2_d, top2_q, top2_d;
  logic signed [sqcb_pkg::POS_W-1:0]  ol_q, ol_d, ot_q, ot_d;
  logic        [sqcb_pkg::SIZE_W-1:0] os_q, os_d;

  logic signed [sqcb_pkg::PT_W:0] dx, dy;
  wide_t                          prodw;
  wide_t                          lq, tq, sq;

  always_comb begin
    frame_w_d = frame_w_q;
    frame_h_d = frame_h_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sqcb_pkg::CFG_FRAME_WIDTH:  frame_w_d = cfg_data_i;
        sqcb_pkg::CFG_FRAME_HEIGHT: frame_h_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    lx_d = lx_q;
    ly_d = ly_q;
    gx_d = gx_q;
    gy_d = gy_q;
    if (cmd_i.track) begin
      if (point_x_i < lx_q) lx_d = point_x_i;
      if (point_y_i < ly_q) ly_d = point_y_i;
      if (point_x_i > gx_q) gx_d = point_x_i;
      if (point_y_i > gy_q) gy_d = point_y_i;
    end else if (cmd_i.span) begin
      lx_d = sqcb_pkg::TRACK_MAX;
      ly_d = sqcb_pkg::TRACK_MAX;
      gx_d = sqcb_pkg::TRACK_MIN;
      gy_d = sqcb_pkg::TRACK_MIN;
    end
  end

  // spans are never negative once the last point is folded in
  assign dx    = 18'(gx_q) - 18'(lx_q);
  assign dy    = 18'(gy_q) - 18'(ly_q);
  assign prodw = wide_t'({1'b0, prod_q});

  assign lq = clamp(trunc_shift(left2_q, SH_HALF), sqcb_pkg::POS_MIN, sqcb_pkg::POS_MAX);
  assign tq = clamp(trunc_shift(top2_q, SH_HALF), sqcb_pkg::POS_MIN, sqcb_pkg::POS_MAX);
  assign sq = clamp(trunc_shift(side_q, SH_ONE), 0, sqcb_pkg::SIZE_MAX);

  always_comb begin
    left_d  = left_q;
    wid_d   = wid_q;
    ysum_d  = ysum_q;
    limx_d  = limx_q;
    limy_d  = limy_q;
    prod_d  = prod_q;
    top_d   = top_q;
    hgt_d   = hgt_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    r3_d    = r3_q;
    side_d  = side_q;
    left2_d = left2_q;
    top2_d  = top2_q;
    ol_d    = ol_q;
    ot_d    = ot_q;
    os_d    = os_q;
    if (cmd_i.span) begin
      // left = (5*min - max) / 4 scaled, width = 1.5 * span scaled
      left_d = ((wide_t'(lx_q) <<< 2) + wide_t'(lx_q) - wide_t'(gx_q))
               <<< (sqcb_pkg::EXTRA_BITS - 2);
      wid_d  = ((wide_t'(dx) <<< 1) + wide_t'(dx)) <<< (sqcb_pkg::EXTRA_BITS - 1);
      ysum_d = (wide_t'(ly_q) + wide_t'(gy_q)) <<< (sqcb_pkg::EXTRA_BITS - 1);
      prod_d = PROD_W'(dy[sqcb_pkg::PT_W-1:0]) * PROD_W'(sqcb_pkg::Y_SCALE_Q14);
      limx_d = (wide_t'($signed({1'b0, frame_w_q})) - wide_t'(1)) <<< SH_ONE;
      limy_d = (wide_t'($signed({1'b0, frame_h_q})) - wide_t'(1)) <<< SH_ONE;
    end
    if (cmd_i.clip_x) begin
      top_d = ysum_q - prodw;
      hgt_d = prodw <<< 1;
      r0_d  = clip_to(left_q, limx_q);
      r2_d  = clip_to(wid_q, limx_q - left_q);
    end
    if (cmd_i.clip_y) begin
      r1_d = clip_to(top_q, limy_q);
      r3_d = clip_to(hgt_q, limy_q - top_q);
    end
    if (cmd_i.side) begin
      side_d = (r2_q > r3_q) ? r2_q : r3_q;
    end
    if (cmd_i.corner) begin
      // doubled corner keeps the halving exact
      left2_d = (r0_q <<< 1) + r2_q - side_q;
      top2_d  = (r1_q <<< 1) + r3_q - side_q;
    end
    if (cmd_i.load_out) begin
      ol_d = lq[sqcb_pkg::POS_W-1:0];
      ot_d = tq[sqcb_pkg::POS_W-1:0];
      os_d = sq[sqcb_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= sqcb_pkg::FRAME_WIDTH_RST;
      frame_h_q <= sqcb_pkg::FRAME_HEIGHT_RST;
      lx_q      <= sqcb_pkg::TRACK_MAX;
      ly_q      <= sqcb_pkg::TRACK_MAX;
      gx_q      <= sqcb_pkg::TRACK_MIN;
      gy_q      <= sqcb_pkg::TRACK_MIN;
    end else begin
      frame_w_q <= frame_w_d;
      frame_h_q <= frame_h_d;
      lx_q      <= lx_d;
      ly_q      <= ly_d;
      gx_q      <= gx_d;
      gy_q      <= gy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    wid_q   <= wid_d;
    ysum_q  <= ysum_d;
    limx_q  <= limx_d;
    limy_q  <= limy_d;
    prod_q  <= prod_d;
    top_q   <= top_d;
    hgt_q   <= hgt_d;
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    r2_q    <= r2_d;
    r3_q    <= r3_d;
    side_q  <= side_d;
    left2_q <= left2_d;
    top2_q  <= top2_d;
    ol_q    <= ol_d;
    ot_q    <= ot_d;
    os_q    <= os_d;
  end

  assign box_left_o   = ol_q;
  assign box_top_o    = ot_q;
  assign box_width_o  = os_q;
  assign box_height_o = os_q;

endmodule

// ===== sv/square_crop_box_from_keypoints.sv =====
// ----------------------------------------------------------------------------
// square_crop_box_from_keypoints: square crop box from a keypoint stream
// Tracks min/max of keypoints; on the last point of a set emits a widened,
// clipped, squared box in whole pixels.
// ----------------------------------------------------------------------------
//   channel   dir   word                                      moves when
//   pt_sink   in    point_x, point_y, last_point              valid && ready
//   box_src   out   box_left, box_top, box_width, box_height  valid && ready
//   cfg       in    cfg_idx_i, cfg_data_i                     cfg_we_i
//
// A point without last_point only updates the trackers.
// A last point is accepted, then five datapath steps and the output load
// follow, all walked by the controller state machine.
// The box sits in an output register; new points are taken while it waits,
// and only the output load step stalls until that register is free.
// Reset clears trackers, frame size (640 x 480) and output valid.
// ----------------------------------------------------------------------------
module square_crop_box_from_keypoints #(
  parameter int FRAC_BITS = sqcb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sqcb_point_if.sink                        pt_sink,
  sqcb_box_if.source                        box_src,
  input  logic                              cfg_we_i,
  input  logic [sqcb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sqcb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  sqcb_pkg::cmd_t cmd;
  logic           in_ready;
  logic           out_valid;

  sqcb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pt_sink.valid),
    .last_point_i (pt_sink.last_point),
    .in_ready_o   (in_ready),
    .out_ready_i  (box_src.ready),
    .out_valid_o  (out_valid),
    .cmd_o        (cmd)
  );

  sqcb_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .point_x_i    (pt_sink.point_x),
    .point_y_i    (pt_sink.point_y),
    .box_left_o   (box_src.box_left),
    .box_top_o    (box_src.box_top),
    .box_width_o  (box_src.box_width),
    .box_height_o (box_src.box_height)
  );

  assign pt_sink.ready = in_ready;
  assign box_src.valid = out_valid;

endmodule

// ===== bench/tb_square_crop_box_from_keypoints.sv =====
// ----------------------------------------------------------------------------
// tb_square_crop_box_from_keypoints: self-checking bench for the crop box block
// Streams keypoint sets into the block under several frame sizes and checks
// each box word against a behavioral predictor or a hand-computed box. It runs
// a short directed list, then random sets with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_square_crop_box_from_keypoints;
  import sqcb_pkg::*;

  localparam int     FRAC_BITS   = FRAC_BITS_DEF;
  localparam int     PHASE_ITEMS = 70;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic signed [PT_W-1:0] coord_t;

  typedef struct packed {
    logic signed [POS_W-1:0] box_left;
    logic signed [POS_W-1:0] box_top;
    logic [SIZE_W-1:0]       box_width;
    logic [SIZE_W-1:0]       box_height;
  } box_t;

  // directed word; "typed" rows carry a hand-computed box
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   lp;
    logic   typed;
    box_t   want;
  } pt_row_t;

  localparam box_t BOX_ZERO = '{box_left: '0, box_top: '0, box_width: '0, box_height: '0};

  localparam int N_ROWS = 20;
  localparam pt_row_t DIR_ROWS [N_ROWS] = '{
    '{px: 17'sd0,      py: 17'sd0,      lp: 1'b1, typed: 1'b1, want: BOX_ZERO},
    '{px: 17'sd65535,  py: 17'sd65535,  lp: 1'b1, typed: 1'b1,
      want: '{box_left: 13'sd639, box_top: 13'sd479, box_width: '0, box_height: '0}},
    '{px: -17'sd65536, py: -17'sd65536, lp: 1'b1, typed: 1'b1, want: BOX_ZERO},
    '{px: -17'sd65536, py: -17'sd65536, lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd65535,  py: 17'sd65535,  lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd1600,   py: 17'sd1280,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd4800,   py: 17'sd1440,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd3200,   py: 17'sd4000,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd1601,   py: 17'sd1283,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd1615,   py: 17'sd1299,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd0,      py: 17'sd3200,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd8000,   py: 17'sd3300,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd4000,   py: 17'sd0,      lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd4100,   py: 17'sd7000,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd10000,  py: 17'sd7600,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd10200,  py: 17'sd7660,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'h0AAAA,   py: 17'h15555,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'h15555,   py: 17'h0AAAA,   lp: 1'b1, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd3000,   py: 17'sd3000,   lp: 1'b0, typed: 1'b0, want: BOX_ZERO},
    '{px: 17'sd3000,   py: 17'sd3000,   lp: 1'b1, typed: 1'b1,
      want: '{box_left: 13'sd187, box_top: 13'sd187, box_width: '0, box_height: '0}}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sqcb_point_if pt_ch ();
  sqcb_box_if   box_ch ();

  square_crop_box_from_keypoints #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_sink    (pt_ch),
    .box_src    (box_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  longint frame_w_now;
  longint frame_h_now;
  longint lo_x, lo_y, hi_x, hi_y;
  box_t   box_due [$];
  int     err_cnt;
  longint cycle_cnt;

  // stimulus side channel to the monitor
  logic row_typed;
  box_t row_want;

  // idling controls
  bit tx_calm;
  bit rx_calm;
  int rx_stall;
  int rx_draw;

  function automatic longint clamp(longint v, longint lo, longint hi);
    longint t;
    t = (v > hi) ? hi : v;
    return (t < lo) ? lo : t;
  endfunction

  // widen, clip, then square the box held by the trackers
  function automatic box_t square_box(longint lx, longint gx, longint ly, longint gy,
                                      longint fw, longint fh);
    longint one, lim_x, lim_y, x0, y0, w, h, cx, cy, cw, ch, side, l2, t2;
    box_t b;
    one   = longint'(1) << (FRAC_BITS + EXTRA_BITS);
    lim_x = (fw - 1) * one;
    lim_y = (fh - 1) * one;
    x0    = (5 * lx - gx) * (longint'(1) << (EXTRA_BITS - 2));
    w     = 3 * (gx - lx) * (longint'(1) << (EXTRA_BITS - 1));
    y0    = (ly + gy) * (longint'(1) << (EXTRA_BITS - 1))
            - longint'(Y_SCALE_Q14) * (gy - ly);
    h     = 2 * longint'(Y_SCALE_Q14) * (gy - ly);
    cx    = clamp(x0, 0, lim_x);
    cy    = clamp(y0, 0, lim_y);
    cw    = clamp(w, 0, lim_x - x0);
    ch    = clamp(h, 0, lim_y - y0);
    side  = (cw > ch) ? cw : ch;
    // corner has one extra fraction bit so halving stays exact
    l2    = 2 * cx + cw - side;
    t2    = 2 * cy + ch - side;
    b.box_left   = POS_W'(clamp(l2 / (2 * one), POS_MIN, POS_MAX));
    b.box_top    = POS_W'(clamp(t2 / (2 * one), POS_MIN, POS_MAX));
    b.box_width  = SIZE_W'(clamp(side / one, 0, SIZE_MAX));
    b.box_height = b.box_width;
    return b;
  endfunction

  task automatic clear_trackers();
    lo_x = longint'(TRACK_MAX);
    lo_y = longint'(TRACK_MAX);
    hi_x = longint'(TRACK_MIN);
    hi_y = longint'(TRACK_MIN);
  endtask

  task automatic check_box(input box_t got);
    box_t want;
    if (box_due.size() == 0) begin
      $error("box word with nothing expected: left %0d top %0d width %0d height %0d",
             got.box_left, got.box_top, got.box_width, got.box_height);
      err_cnt++;
    end else begin
      want = box_due.pop_front();
      if (got.box_left !== want.box_left) begin
        $error("box_left expected %0d actual %0d", want.box_left, got.box_left);
        err_cnt++;
      end
      if (got.box_top !== want.box_top) begin
        $error("box_top expected %0d actual %0d", want.box_top, got.box_top);
        err_cnt++;
      end
      if (got.box_width !== want.box_width) begin
        $error("box_width expected %0d actual %0d", want.box_width, got.box_width);
        err_cnt++;
      end
      if (got.box_height !== want.box_height) begin
        $error("box_height expected %0d actual %0d", want.box_height, got.box_height);
        err_cnt++;
      end
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // box receiver: random stall before each word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      box_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else if (box_ch.valid && box_ch.ready) begin
      rx_draw = rx_calm ? 0 : $urandom_range(0, 15);
      rx_stall     <= rx_draw;
      box_ch.ready <= (rx_draw == 0);
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      box_ch.ready <= (rx_stall == 1);
    end else begin
      box_ch.ready <= 1'b1;
    end
  end

  // monitor: check box words, fold accepted points into the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (box_ch.valid && box_ch.ready)
        check_box('{box_left: box_ch.box_left, box_top: box_ch.box_top,
                    box_width: box_ch.box_width, box_height: box_ch.box_height});
      if (pt_ch.valid && pt_ch.ready) begin
        if (longint'(pt_ch.point_x) < lo_x) lo_x = longint'(pt_ch.point_x);
        if (longint'(pt_ch.point_x) > hi_x) hi_x = longint'(pt_ch.point_x);
        if (longint'(pt_ch.point_y) < lo_y) lo_y = longint'(pt_ch.point_y);
        if (longint'(pt_ch.point_y) > hi_y) hi_y = longint'(pt_ch.point_y);
        if (pt_ch.last_point) begin
          if (row_typed)
            box_due.push_back(row_want);
          else
            box_due.push_back(square_box(lo_x, hi_x, lo_y, hi_y, frame_w_now, frame_h_now));
          clear_trackers();
        end
      end
    end
  end

  task automatic send_point(input coord_t px, input coord_t py, input logic lp,
                            input logic typed, input box_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_ch.valid      <= 1'b1;
    pt_ch.point_x    <= px;
    pt_ch.point_y    <= py;
    pt_ch.last_point <= lp;
    row_typed        <= typed;
    row_want         <= want;
    do @(posedge clk_i); while (!pt_ch.ready);
  endtask

  // hold off until every box is out and the datapath has settled
  task automatic drain();
    pt_ch.valid <= 1'b0;
    do @(posedge clk_i); while (box_due.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_frame(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH)
      frame_w_now = longint'(val & 32'h1FFF);
    else
      frame_h_now = longint'(val & 32'h1FFF);
  endtask

  // half in-frame coordinates, some small negatives, edge values, full-range noise
  function automatic coord_t pick_coord(longint span);
    longint top_val;
    top_val = (span << FRAC_BITS > 65535) ? 65535 : (span << FRAC_BITS);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return PT_W'($urandom_range(0, int'(top_val)));
      4:          return PT_W'($urandom);
      5:          return $urandom_range(0, 1) ? TRACK_MAX : TRACK_MIN;
      default:    return -PT_W'($urandom_range(0, 512));
    endcase
  endfunction

  task automatic random_phase(input int unsigned fw, input int unsigned fh);
    int sent, len;
    coord_t cx, cy;
    write_frame(CFG_FRAME_WIDTH, fw);
    write_frame(CFG_FRAME_HEIGHT, fh);
    rx_calm = ($urandom_range(0, 2) == 0);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        cx = pick_coord(frame_w_now);
        cy = pick_coord(frame_h_now);
        send_point(cx, cy, k == len - 1, 1'b0, BOX_ZERO);
      end
      sent += len;
    end
    drain();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    pt_ch.valid      = 1'b0;
    pt_ch.point_x    = '0;
    pt_ch.point_y    = '0;
    pt_ch.last_point = 1'b0;
    box_ch.ready     = 1'b0;
    row_typed        = 1'b0;
    row_want         = BOX_ZERO;
    tx_calm          = 1'b0;
    rx_calm          = 1'b0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    frame_w_now      = longint'(FRAME_WIDTH_RST);
    frame_h_now      = longint'(FRAME_HEIGHT_RST);
    clear_trackers();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed list at the reset frame size
    for (int r = 0; r < N_ROWS; r++)
      send_point(DIR_ROWS[r].px, DIR_ROWS[r].py, DIR_ROWS[r].lp,
                 DIR_ROWS[r].typed, DIR_ROWS[r].want);
    drain();

    // frame size zero clips everything to the origin
    write_frame(CFG_FRAME_WIDTH, 0);
    write_frame(CFG_FRAME_HEIGHT, 0);
    send_point(17'sd1000, 17'sd2000, 1'b0, 1'b0, BOX_ZERO);
    send_point(17'sd5000, 17'sd6000, 1'b1, 1'b1, BOX_ZERO);
    drain();

    random_phase(1, 1);
    random_phase(4096, 4096);
    random_phase(0, 0);
    random_phase(8191, 8191);
    random_phase(1920, 1080);
    random_phase($urandom_range(1, 4096), $urandom_range(1, 4096));
    random_phase(640, 480);

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && box_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
